@@ src/mld_pkg.sv @@
// ----------------------------------------------------------------------------
// Microgrid load dispatch package
// Shared types, constants and table/arithmetic functions for the dispatch
// controller. All currents are in centiamps.
// ----------------------------------------------------------------------------
package mld_pkg;

    // Signed working width: covers -1122..+1322 cA intermediate values
    localparam int AMP_W = 12;

    typedef logic signed [AMP_W-1:0] amp_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CHARGE    = 2'd1,
        MODE_DISCHARGE = 2'd2
    } mode_t;

    // Decision produced by the dispatch logic for one control beat
    typedef struct packed {
        mode_t      mode;
        logic [2:0] supply;
        logic [7:0] mains;
    } dispatch_t;

    localparam logic [6:0] LEVEL_MAX       = 7'd100;
    localparam logic [6:0] THRESHOLD_RESET = 7'd30;
    localparam logic [7:0] MAINS_LIMIT     = 8'd200;
    localparam amp_t       MAINS_LIMIT_A   = 12'sd200;
    localparam amp_t       MODE_AMPS       = 12'sd100;
    localparam amp_t       TOLERANCE       = 12'sd10;
    localparam amp_t       DISCHARGE_GAP   = 12'sd200;
    localparam amp_t       CHARGE_GAP      = 12'sd100;

    // duty = floor(mains*255/400) = floor(mains*51/80), exact for mains <= 255
    // via the reciprocal 10445 / 2^14
    localparam int         DUTY_SHIFT = 14;
    localparam logic [13:0] DUTY_MULT = 14'd10445;

    // Demanded current of each load pattern, index = requested loads
    function automatic amp_t load_amps(input logic [2:0] idx);
        amp_t amps;
        case (idx)
            3'd0:    amps = 12'sd0;
            3'd1:    amps = 12'sd80;
            3'd2:    amps = 12'sd200;
            3'd3:    amps = 12'sd280;
            3'd4:    amps = 12'sd120;
            3'd5:    amps = 12'sd200;
            3'd6:    amps = 12'sd320;
            3'd7:    amps = 12'sd400;
            default: amps = 12'sd0;
        endcase
        return amps;
    endfunction

    // Limit the mains draw to 0..2 A
    function automatic logic [7:0] clamp_mains(input amp_t v);
        logic [7:0] r;
        if (v > MAINS_LIMIT_A)
            r = MAINS_LIMIT;
        else if (v < 12'sd0)
            r = 8'd0;
        else
            r = v[7:0];
        return r;
    endfunction

    function automatic logic [6:0] mains_to_duty(input logic [7:0] mains);
        logic [21:0] prod;
        prod = {14'd0, mains} * {8'd0, DUTY_MULT};
        return prod[DUTY_SHIFT +: 7];
    endfunction

endpackage

@@ src/microgrid_load_dispatch.sv @@
// ----------------------------------------------------------------------------
// Microgrid load dispatch controller
// Control beats decide battery mode, supplied loads and mains draw; tick
// beats step the battery percentage. One result beat per input beat.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while the output side keeps up,
// and returns exactly one result beat for each, in order. A beat passes
// through an input register and the dispatch logic into the result
// register, where its result beat is presented and can be taken when the
// output side is ready. Throughput is one beat per cycle unless the output
// stalls, set by the combinational decision path between the two registers.
// The controller state (battery mode, battery level, supplied loads, mains
// current) is updated as each beat leaves the input register, so
// consecutive beats see each other's effects without any bubble.
// A control beat (func = 0) uses wind_current + solar_current as renewable
// supply, looks up the demand of load_request, and sets the mode, supplied
// loads and mains current (clamped to 0..200 cA). A tick beat (func = 1)
// ignores the readings, repeats the held decision and moves battery_level
// up when charging or down when discharging, held within 0..100.
// mains_duty is floor(mains_current * 255 / 400). battery_threshold is
// written through cfg_write/cfg_data, resets to 30, and should only be
// changed while no beat is in flight.
// ----------------------------------------------------------------------------
module microgrid_load_dispatch
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_write,
    input  logic [6:0]          cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [8:0]          wind_current,
    input  logic [8:0]          solar_current,
    input  logic [2:0]          load_request,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          battery_mode,
    output logic [2:0]          load_switches,
    output logic [7:0]          mains_current,
    output logic [6:0]          mains_duty,
    output logic [6:0]          battery_level
);

    import mld_pkg::*;

    // Configuration
    logic [6:0] threshold_reg;

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_func_reg;
    logic [9:0] s1_renew_reg;
    logic [2:0] s1_req_reg;

    // Controller state
    mode_t      mode_reg, mode_next;
    logic [6:0] level_reg, level_next;
    logic [2:0] supply_reg, supply_next;
    logic [7:0] mains_reg, mains_next;

    // Result register
    logic       res_valid_reg, res_valid_next;
    mode_t      res_mode_reg;
    logic [2:0] res_supply_reg;
    logic [7:0] res_mains_reg;
    logic [6:0] res_level_reg;

    logic       out_free;
    logic       in_fire;
    logic       s1_fire;
    dispatch_t  decision;

    // Advance when the result register is empty or being drained
    assign out_free = !res_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;
    assign s1_fire  = s1_valid_reg && out_free;

    mld_dispatch u_dispatch
    (
        .renew     (s1_renew_reg),
        .req       (s1_req_reg),
        .level     (level_reg),
        .threshold (threshold_reg),
        .result    (decision)
    );

    // Next controller state for the beat leaving the input register
    always_comb
    begin
        mode_next   = mode_reg;
        level_next  = level_reg;
        supply_next = supply_reg;
        mains_next  = mains_reg;
        if (s1_fire)
        begin
            if (!s1_func_reg)
            begin
                mode_next   = decision.mode;
                supply_next = decision.supply;
                mains_next  = decision.mains;
            end
            else
            begin
                case (mode_reg)
                    MODE_CHARGE:
                        if (level_reg < LEVEL_MAX)
                            level_next = level_reg + 7'd1;
                    MODE_DISCHARGE:
                        if (level_reg != 7'd0)
                            level_next = level_reg - 7'd1;
                    default:
                        level_next = level_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        // Load wins over drain; otherwise drop on drain
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_fire)
            res_valid_next = 1'b1;
        else if (out_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            level_reg     <= 7'd0;
            supply_reg    <= 3'd0;
            mains_reg     <= 8'd0;
        end
        else
        begin
            if (cfg_write)
                threshold_reg <= cfg_data;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            mode_reg      <= mode_next;
            level_reg     <= level_next;
            supply_reg    <= supply_next;
            mains_reg     <= mains_next;
        end
    end

    // Payload registers: hold unless a beat moves in
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg  <= func;
            s1_renew_reg <= {1'b0, wind_current} + {1'b0, solar_current};
            s1_req_reg   <= load_request;
        end
        if (s1_fire)
        begin
            res_mode_reg   <= mode_next;
            res_supply_reg <= supply_next;
            res_mains_reg  <= mains_next;
            res_level_reg  <= level_next;
        end
    end

    assign out_valid     = res_valid_reg;
    assign battery_mode  = res_mode_reg;
    assign load_switches = res_supply_reg;
    assign mains_current = res_mains_reg;
    assign mains_duty    = mains_to_duty(res_mains_reg);
    assign battery_level = res_level_reg;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_MAX)
        else $error("battery level above maximum");

    a_mains_range: assert property (@(posedge clk) disable iff (!rst_n)
        mains_reg <= MAINS_LIMIT)
        else $error("mains current above limit");

    a_supply_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_func_reg) |=> ((supply_reg & ~$past(s1_req_reg)) == 3'd0))
        else $error("supplied loads outside the request");

    a_charge_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_func_reg && mode_reg == MODE_CHARGE)
        |=> (level_reg >= $past(level_reg)))
        else $error("battery level fell while charging");

    a_tick_holds_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_func_reg) |=> ($stable(mode_reg) && $stable(mains_reg)))
        else $error("tick beat changed the dispatch decision");
`endif

endmodule

@@ src/mld_dispatch.sv @@
// ----------------------------------------------------------------------------
// Microgrid dispatch decision
// Picks battery mode, supplied loads and the clamped mains current for one
// control beat from the renewable current, the request and the battery level.
// ----------------------------------------------------------------------------
module mld_dispatch
(
    input  logic [9:0]          renew,
    input  logic [2:0]          req,
    input  logic [6:0]          level,
    input  logic [6:0]          threshold,
    output mld_pkg::dispatch_t  result
);

    import mld_pkg::*;

    amp_t       renew_a;
    amp_t       called;
    amp_t       diff;
    amp_t       mode_a;
    amp_t       need_a;
    amp_t       avail;
    amp_t       avail_tol;
    mode_t      mode;
    logic [7:0] need;
    logic [2:0] sup;

    assign renew_a   = $signed({2'b00, renew});
    assign called    = load_amps(req);
    assign diff      = called - renew_a;

    // Discharge on a large deficit unless the battery is empty, charge on surplus or when low
    always_comb
    begin
        if (diff > DISCHARGE_GAP && level != 7'd0)
            mode = MODE_DISCHARGE;
        else if ((level < threshold && diff < CHARGE_GAP) || diff < -CHARGE_GAP)
            mode = MODE_CHARGE;
        else
            mode = MODE_IDLE;
    end

    always_comb
    begin
        case (mode)
            MODE_CHARGE:    mode_a = MODE_AMPS;
            MODE_DISCHARGE: mode_a = -MODE_AMPS;
            default:        mode_a = 12'sd0;
        endcase
    end

    assign need      = clamp_mains(diff + mode_a);
    assign need_a    = $signed({4'd0, need});
    assign avail     = need_a + renew_a - mode_a;
    assign avail_tol = avail + TOLERANCE;

    // Full request if it fits, otherwise the fallback for the pattern
    always_comb
    begin
        case (req)
            3'd7:
            begin
                sup = (avail_tol >= load_amps(3'd4)) ? 3'd4 : 3'd0;
                if (avail_tol >= load_amps(3'd5))
                    sup = 3'd5;
                if (avail_tol >= load_amps(3'd6))
                    sup = 3'd6;
            end
            3'd6, 3'd5:
                sup = (avail_tol >= load_amps(3'd4)) ? 3'd4 : 3'd0;
            3'd3:
                sup = (avail_tol >= load_amps(3'd2)) ? 3'd2 : 3'd0;
            default:
                sup = 3'd0;
        endcase
        if (avail_tol >= called)
            sup = req;
    end

    assign result.mode   = mode;
    assign result.supply = sup;
    assign result.mains  = clamp_mains(load_amps(sup) - renew_a + mode_a);

endmodule

@@ dv/mld_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatch testbench package
// Beat kind codes shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
package mld_tb_pkg;

    localparam logic FUNC_CONTROL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

endpackage

@@ dv/mld_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatch checker
// Watches the config port and both beat channels, predicts the dispatch
// decision and battery level for every input beat, and compares each result
// beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module mld_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [6:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       func,
    input  logic [8:0] wind_current,
    input  logic [8:0] solar_current,
    input  logic [2:0] load_request,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] battery_mode,
    input  logic [2:0] load_switches,
    input  logic [7:0] mains_current,
    input  logic [6:0] mains_duty,
    input  logic [6:0] battery_level,
    output int         mismatches,
    output int         outstanding
);

    import mld_pkg::*;
    import mld_tb_pkg::*;

    // Load patterns: bit2 load1, bit1 load2, bit0 load3
    localparam logic [2:0] NO_LOAD   = 3'b000;
    localparam logic [2:0] LOAD3     = 3'b001;
    localparam logic [2:0] LOAD2     = 3'b010;
    localparam logic [2:0] LOAD2_3   = 3'b011;
    localparam logic [2:0] LOAD1     = 3'b100;
    localparam logic [2:0] LOAD1_3   = 3'b101;
    localparam logic [2:0] LOAD1_2   = 3'b110;
    localparam logic [2:0] ALL_LOADS = 3'b111;

    localparam int SLACK_CA   = 10;
    localparam int MAINS_CAP  = 200;
    localparam int MODE_CA    = 100;
    localparam int LEVEL_TOP  = 100;

    typedef struct packed {
        mode_t      mode;
        logic [2:0] switches;
        logic [7:0] mains;
        logic [6:0] duty;
        logic [6:0] level;
    } grid_result_t;

    logic [6:0]   threshold;
    mode_t        mode_q;
    int           level_q;
    logic [2:0]   supply_q;
    int           mains_q;
    grid_result_t results_due[$];

    function automatic int demand_ca(input logic [2:0] pattern);
        int ca;
        case (pattern)
            NO_LOAD:   ca = 0;
            LOAD3:     ca = 80;
            LOAD2:     ca = 200;
            LOAD2_3:   ca = 280;
            LOAD1:     ca = 120;
            LOAD1_3:   ca = 200;
            LOAD1_2:   ca = 320;
            default:   ca = 400;
        endcase
        return ca;
    endfunction

    function automatic int fit_mains(input int v);
        int r;
        r = v;
        if (r > MAINS_CAP)
            r = MAINS_CAP;
        if (r < 0)
            r = 0;
        return r;
    endfunction

    // Advance the predicted controller state by one beat and queue its result
    task automatic dispatch_beat(input logic kind, input int renew, input logic [2:0] req);
        int           called;
        int           bias;
        int           need;
        int           avail;
        logic [2:0]   sup;
        grid_result_t r;
        if (kind == FUNC_TICK)
        begin
            if (mode_q == MODE_CHARGE && level_q < LEVEL_TOP)
                level_q = level_q + 1;
            else if (mode_q == MODE_DISCHARGE && level_q > 0)
                level_q = level_q - 1;
        end
        else
        begin
            called = demand_ca(req);
            if (called - renew > 200 && level_q > 0)
                mode_q = MODE_DISCHARGE;
            else if ((level_q < int'(threshold) && renew - called + 200 > 100)
                     || renew - called > 100)
                mode_q = MODE_CHARGE;
            else
                mode_q = MODE_IDLE;
            bias = (mode_q == MODE_CHARGE) ? MODE_CA :
                   (mode_q == MODE_DISCHARGE) ? -MODE_CA : 0;
            need  = fit_mains(called - renew + bias);
            avail = need + renew - bias;

            // Fall back to the largest fallback pattern for the request that the supply can carry
            case (req)
                ALL_LOADS:
                begin
                    sup = (avail - demand_ca(LOAD1) >= -SLACK_CA) ? LOAD1 : NO_LOAD;
                    if (avail - demand_ca(LOAD1_3) >= -SLACK_CA)
                        sup = LOAD1_3;
                    if (avail - demand_ca(LOAD1_2) >= -SLACK_CA)
                        sup = LOAD1_2;
                end
                LOAD1_2, LOAD1_3:
                    sup = (avail - demand_ca(LOAD1) >= -SLACK_CA) ? LOAD1 : NO_LOAD;
                LOAD2_3:
                    sup = (avail - demand_ca(LOAD2) >= -SLACK_CA) ? LOAD2 : NO_LOAD;
                default:
                    sup = NO_LOAD;
            endcase
            if (avail - called >= -SLACK_CA)
                sup = req;
            supply_q = sup;
            mains_q  = fit_mains(demand_ca(sup) - renew + bias);
        end
        r.mode     = mode_q;
        r.switches = supply_q;
        r.mains    = mains_q[7:0];
        r.duty     = 7'((mains_q * 255) / 400);
        r.level    = level_q[6:0];
        results_due.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        grid_result_t want;
        if (!rst_n)
        begin
            threshold   = THRESHOLD_RESET;
            mode_q      = MODE_IDLE;
            level_q     = 0;
            supply_q    = NO_LOAD;
            mains_q     = 0;
            mismatches  = 0;
            results_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
                threshold = cfg_data;

            // Retire the result beat first; it always belongs to an older input beat
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"%t: result beat with nothing pending: ",
                                  "mode=%0d sw=%0d mains=%0d duty=%0d level=%0d"},
                                 $realtime, battery_mode, load_switches, mains_current,
                                 mains_duty, battery_level);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (battery_mode !== want.mode || load_switches !== want.switches ||
                        mains_current !== want.mains || mains_duty !== want.duty ||
                        battery_level !== want.level)
                    begin
                        if (mismatches < 10)
                            $display({"%t: exp mode=%0d sw=%0d mains=%0d duty=%0d ",
                                      "level=%0d, got mode=%0d sw=%0d mains=%0d ",
                                      "duty=%0d level=%0d"},
                                     $realtime, want.mode, want.switches, want.mains,
                                     want.duty, want.level, battery_mode, load_switches,
                                     mains_current, mains_duty, battery_level);
                        mismatches = mismatches + 1;
                    end
                end
            end

            if (in_valid && in_ready)
                dispatch_beat(func, int'(wind_current) + int'(solar_current),
                              load_request);

            outstanding = results_due.size();
        end
    end

endmodule

@@ dv/tb_microgrid_load_dispatch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microgrid load dispatch testbench
// Drives control and tick beats into the dispatch controller with random
// gaps and output stalls, sweeps the battery threshold across phases, and
// lets the checker predict and compare every result beat.
// ----------------------------------------------------------------------------
module tb_microgrid_load_dispatch;

    import mld_pkg::*;
    import mld_tb_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [6:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic       func;
    logic [8:0] wind_current;
    logic [8:0] solar_current;
    logic [2:0] load_request;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] battery_mode;
    logic [2:0] load_switches;
    logic [7:0] mains_current;
    logic [6:0] mains_duty;
    logic [6:0] battery_level;

    int         mismatches;
    int         outstanding;

    // When low, both sides run back to back with no gaps or stalls
    logic       throttle;

    microgrid_load_dispatch dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .wind_current  (wind_current),
        .solar_current (solar_current),
        .load_request  (load_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .battery_mode  (battery_mode),
        .load_switches (load_switches),
        .mains_current (mains_current),
        .mains_duty    (mains_duty),
        .battery_level (battery_level)
    );

    mld_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .wind_current  (wind_current),
        .solar_current (solar_current),
        .load_request  (load_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .battery_mode  (battery_mode),
        .load_switches (load_switches),
        .mains_current (mains_current),
        .mains_duty    (mains_duty),
        .battery_level (battery_level),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop; a correct run needs a small fraction of this
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Send one beat: optionally idle first, then hold valid and payload
    // until the beat is taken. Valid stays high across back-to-back beats.
    task automatic send_beat(input logic kind, input logic [8:0] wind,
                             input logic [8:0] solar, input logic [2:0] req);
        int gap;
        gap = throttle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= kind;
        wind_current  <= wind;
        solar_current <= solar;
        load_request  <= req;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Tick beats ignore the readings, so fill them with noise
    task automatic send_ticks(input int count);
        repeat (count)
            send_beat(FUNC_TICK, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                      3'($urandom_range(0, 7)));
    endtask

    // Hold off the sender until every result beat has drained
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [6:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly realistic sensor readings, some over range, some at the rails
    function automatic logic [8:0] pick_current();
        int k;
        logic [8:0] v;
        k = $urandom_range(0, 9);
        if (k < 7)
            v = 9'($urandom_range(0, 330));
        else if (k < 9)
            v = 9'($urandom_range(0, 511));
        else
        begin
            case ($urandom_range(0, 3))
                0:       v = 9'd0;
                1:       v = 9'd330;
                2:       v = 9'd256;
                default: v = 9'd511;
            endcase
        end
        return v;
    endfunction

    // A control beat followed by a run of ticks; now and then a long run
    // walks the battery level into either rail.
    task automatic random_phase(input int count);
        int sent;
        int run;
        sent = 0;
        while (sent < count)
        begin
            send_beat(FUNC_CONTROL, pick_current(), pick_current(), 3'($urandom_range(0, 7)));
            sent = sent + 1;
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 110) : $urandom_range(0, 3);
            send_ticks(run);
            sent = sent + run;
        end
    endtask

    // Receiver: per beat, stall for a random count, then hold ready until
    // a result beat is taken.
    initial
    begin : receiver
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = throttle ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        logic [6:0] level_set;
        throttle      = 1'b1;
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_data      <= 7'd0;
        in_valid      <= 1'b0;
        func          <= FUNC_CONTROL;
        wind_current  <= 9'd0;
        solar_current <= 9'd0;
        load_request  <= 3'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: every request with no renewables, starting from an empty
        // battery at the reset threshold
        for (int r = 0; r < 8; r++)
            send_beat(FUNC_CONTROL, 9'd0, 9'd0, 3'(r));
        // Full request exactly at the tolerance edge, then one short of it
        send_beat(FUNC_CONTROL, 9'd100, 9'd90, 3'b111);
        send_beat(FUNC_CONTROL, 9'd100, 9'd89, 3'b111);
        // Charge from mains, then tick the level up a few steps
        send_beat(FUNC_CONTROL, 9'd0, 9'd0, 3'b000);
        send_ticks(3);
        // Largest readings, then the nominal maxima
        send_beat(FUNC_CONTROL, 9'd511, 9'd511, 3'b111);
        send_ticks(1);
        send_beat(FUNC_CONTROL, 9'd330, 9'd330, 3'b011);
        // Heavy demand with nothing renewable forces discharge; tick past empty
        send_beat(FUNC_CONTROL, 9'd0, 9'd0, 3'b111);
        send_ticks(7);

        // Random phases across threshold settings, extremes included;
        // the third phase runs both sides back to back
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       level_set = 7'd0;
                1:       level_set = 7'd127;
                2:       level_set = 7'd100;
                3:       level_set = 7'd1;
                4:       level_set = 7'($urandom_range(0, 127));
                default: level_set = THRESHOLD_RESET;
            endcase
            write_threshold(level_set);
            throttle = (p != 2);
            random_phase(310);
        end

        // Drop valid, wait out the pipeline, then give the verdict
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
src/mld_pkg.sv
src/mld_dispatch.sv
src/microgrid_load_dispatch.sv
dv/mld_tb_pkg.sv
dv/mld_checker.sv
dv/tb_microgrid_load_dispatch.sv
